// File: rtl/hfbe_pkg.sv
// ----------------------------------------------------------------------------
// hfbe_pkg
// Shared types, codes and the crc helper of the hdlc bit encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hfbe_pkg;

  // action codes on the input tuser field
  localparam logic [1:0] ACT_FLAG = 2'd0;
  localparam logic [1:0] ACT_DATA = 2'd1;
  localparam logic [1:0] ACT_FCS  = 2'd2;

  localparam logic [7:0]  FLAG_PATTERN = 8'h7E;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'h8408;
  localparam logic [2:0]  RUN_LIMIT    = 3'd5;

  // most line bits one byte can produce (8 data plus 2 stuffed zeros)
  localparam int unsigned SEG_BITS = 10;

  // one encoded byte worth of line levels, oldest in bit 0
  typedef struct packed {
    logic [SEG_BITS-1:0] bits;
    logic [3:0]          cnt;
    logic                last;
  } seg_t;

  // reflected crc-16, one byte
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/hfbe_front.sv
// ----------------------------------------------------------------------------
// hfbe_front
// Holds one action, keeps the frame state and encodes one byte per pass
// into nrzi line levels, with zero insertion for data and fcs bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module hfbe_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    in_action,
  input  wire logic [7:0]    in_byte,
  output logic               seg_valid,
  input  wire logic          seg_ready,
  output hfbe_pkg::seg_t     seg
);

  logic        hold_valid;
  logic [1:0]  hold_action;
  logic [7:0]  hold_byte;
  logic        hold_phase;

  logic [15:0] crc;
  logic [2:0]  run;
  logic        lvl;

  logic [15:0] crc_next;
  logic [2:0]  run_next;
  logic        lvl_next;

  logic        fire;
  logic        fcs_first;
  logic        accept;
  logic [7:0]  enc_byte;
  logic        raw;

  hfbe_pkg::seg_t enc;

  assign fire      = hold_valid && seg_ready;
  assign fcs_first = (hold_action == hfbe_pkg::ACT_FCS) && !hold_phase;
  assign in_ready  = !hold_valid || (fire && !fcs_first);
  assign accept    = in_valid && in_ready;

  assign seg_valid = hold_valid;
  assign seg       = enc;

  always_comb begin
    logic [3:0] n;
    logic [2:0] r;
    logic       l;
    enc_byte = hold_byte;
    raw      = 1'b0;
    crc_next = crc;
    enc.last = 1'b1;
    unique case (hold_action)
      hfbe_pkg::ACT_FLAG: begin
        enc_byte = hfbe_pkg::FLAG_PATTERN;
        raw      = 1'b1;
        crc_next = hfbe_pkg::CRC_INIT;
      end
      hfbe_pkg::ACT_DATA: begin
        crc_next = hfbe_pkg::crc_update(crc, hold_byte);
      end
      hfbe_pkg::ACT_FCS: begin
        enc_byte = hold_phase ? ~crc[15:8] : ~crc[7:0];
        enc.last = hold_phase;
      end
      default: begin
        enc_byte = hold_byte;
      end
    endcase

    n = 4'd0;
    r = run;
    l = lvl;
    enc.bits = '0;
    for (int i = 0; i < 8; i++) begin
      if (enc_byte[i]) begin
        r = r + 3'd1;
      end else begin
        r = 3'd0;
        l = ~l;
      end
      enc.bits[n] = l;
      n = n + 4'd1;
      if (!raw && r >= hfbe_pkg::RUN_LIMIT) begin
        r = 3'd0;
        l = ~l;
        enc.bits[n] = l;
        n = n + 4'd1;
      end
    end
    enc.cnt  = n;
    run_next = raw ? 3'd0 : r;
    lvl_next = l;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      hold_phase <= 1'b0;
      crc        <= hfbe_pkg::CRC_INIT;
      run        <= 3'd0;
      lvl        <= 1'b1;
    end else begin
      if (fire) begin
        crc <= crc_next;
        run <= run_next;
        lvl <= lvl_next;
      end
      // unused action code is taken and dropped
      if (accept && (in_action == hfbe_pkg::ACT_FLAG || in_action == hfbe_pkg::ACT_DATA ||
                     in_action == hfbe_pkg::ACT_FCS)) begin
        hold_valid <= 1'b1;
        hold_phase <= 1'b0;
      end else if (fire) begin
        if (fcs_first) begin
          hold_phase <= 1'b1;
        end else begin
          hold_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_action <= in_action;
      hold_byte   <= in_byte;
    end
  end

endmodule

`default_nettype wire

// File: rtl/hfbe_ser.sv
// ----------------------------------------------------------------------------
// hfbe_ser
// Buffers one encoded segment and shifts line levels out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module hfbe_ser (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           seg_valid,
  output logic                seg_ready,
  input  wire hfbe_pkg::seg_t seg,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic                out_bit,
  output logic                out_last
);

  logic           buf_valid;
  hfbe_pkg::seg_t buf_seg;

  logic [hfbe_pkg::SEG_BITS-1:0] sh_bits;
  logic [3:0]                    sh_cnt;
  logic                          sh_last;

  logic take;
  logic load;

  assign out_valid = (sh_cnt != 4'd0);
  assign out_bit   = sh_bits[0];
  assign out_last  = sh_last && (sh_cnt == 4'd1);
  assign take      = out_valid && out_ready;
  // refill the shifter when empty or on its final bit
  assign load      = buf_valid && ((sh_cnt == 4'd0) || (take && sh_cnt == 4'd1));
  assign seg_ready = !buf_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      sh_cnt    <= 4'd0;
    end else begin
      if (seg_valid && seg_ready) begin
        buf_valid <= 1'b1;
      end else if (load) begin
        buf_valid <= 1'b0;
      end
      if (load) begin
        sh_cnt <= buf_seg.cnt;
      end else if (take) begin
        sh_cnt <= sh_cnt - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (seg_valid && seg_ready) begin
      buf_seg <= seg;
    end
    if (load) begin
      sh_bits <= buf_seg.bits;
      sh_last <= buf_seg.last;
    end else if (take) begin
      sh_bits <= {1'b0, sh_bits[hfbe_pkg::SEG_BITS-1:1]};
    end
  end

endmodule

`default_nettype wire

// File: rtl/hdlc_frame_bit_encoder_top.sv
// ----------------------------------------------------------------------------
// hdlc_frame_bit_encoder_top
// HDLC transmit bit encoder: flag, stuffed data with crc-16, and fcs.
// ----------------------------------------------------------------------------
// Input stream: one request per action. tuser carries the action (flag, data
// byte, fcs), tdata the byte. Output stream: one request per line bit, the
// nrzi level in tdata bit 0, tlast on the final bit of each action.
// A held action is encoded one byte per cycle into a segment buffer while
// that buffer has room, and a shifter sends one line bit per cycle while the
// receiver is ready. A flag or data byte gives 8 to 10 bits, an fcs 16 to 20,
// so the sustained rate is set by the one-bit-per-cycle shifter. The first
// bit passes the held action, the segment buffer and the shifter in turn. A
// new action is taken while earlier bits are still being shifted out.
// Reset empties all stages, sets the crc to all ones, clears the ones run
// and sets the nrzi line level high. When the receiver stalls, the current
// bit holds, and the buffer and held action fill before tready drops.
// The unused action code is taken and gives no bits.
// ----------------------------------------------------------------------------
`default_nettype none

module hdlc_frame_bit_encoder_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  wire logic [1:0] s_axis_tuser,   // [1:0] action
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [0] line_bit, [7:1] zero
  output logic            m_axis_tlast
);

  logic           seg_valid;
  logic           seg_ready;
  hfbe_pkg::seg_t seg;
  logic           line_bit;

  hfbe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_action (s_axis_tuser),
    .in_byte   (s_axis_tdata),
    .seg_valid (seg_valid),
    .seg_ready (seg_ready),
    .seg       (seg)
  );

  hfbe_ser u_ser (
    .clk       (clk),
    .rst       (rst),
    .seg_valid (seg_valid),
    .seg_ready (seg_ready),
    .seg       (seg),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_bit   (line_bit),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, line_bit};

endmodule

`default_nettype wire

// File: rtl/hfbe_checker.sv
// ----------------------------------------------------------------------------
// hfbe_checker
// Port-level checks of the hdlc bit encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hfbe_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast
);

  // nothing left in flight after reset
  a_rst_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_rst_in: assert property (@(posedge clk) rst |=> s_axis_tready)
    else $error("input not ready right after reset");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'd0))
    else $error("output padding bits not zero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output changed");

endmodule

bind hdlc_frame_bit_encoder_top hfbe_checker u_hfbe_checker (.*);

`default_nettype wire

// File: tb/hdlc_frame_bit_encoder_top_tb.sv
// ----------------------------------------------------------------------------
// hdlc_frame_bit_encoder_top_tb
// Self-checking bench for the hdlc transmit bit encoder. Flag, data and fcs
// requests go in on the input stream; every line bit that comes out is
// compared in order against typed levels or a local nrzi/stuffing/crc-16
// encoder. A short table of hand-picked requests comes first, then random
// frames under several source-idle and sink-stall mixes.
// ----------------------------------------------------------------------------

module hdlc_frame_bit_encoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 7;
  localparam int STALL_LIMIT   = 2000;
  localparam int TAIL_CYCLES   = 40;
  localparam int PHASE_ITEMS   = 45;
  localparam int MAX_PRINTED   = 100;

  // the one action code the package leaves unnamed
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic level;
    logic last;
  } line_bit_t;

  // directed row: n_bits == 0 means the encoder model supplies the bits
  typedef struct packed {
    logic [1:0]  act;
    logic [7:0]  data;
    logic [4:0]  n_bits;
    logic [19:0] levels;
  } stim_row_t;

  logic       clk           = 1'b0;
  logic       rst           = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic [1:0] s_axis_tuser  = hfbe_pkg::ACT_FLAG;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int err_count      = 0;
  int quiet_cycles   = 0;

  // encoder state as the line should see it
  logic [15:0] tx_crc   = hfbe_pkg::CRC_INIT;
  logic [2:0]  tx_ones  = 3'd0;
  logic        tx_level = 1'b1;

  line_bit_t line_q[$];
  stim_row_t dir_rows[$];

  hdlc_frame_bit_encoder_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------- encoder

  function automatic logic [15:0] fold_crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ hfbe_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void stuff_byte(input logic [7:0] b, ref line_bit_t bits[$]);
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        tx_ones = tx_ones + 3'd1;
      end else begin
        tx_ones  = 3'd0;
        tx_level = ~tx_level;
      end
      bits.push_back({tx_level, 1'b0});
      // five ones in a row: insert a zero, which toggles the line
      if (tx_ones >= hfbe_pkg::RUN_LIMIT) begin
        tx_ones  = 3'd0;
        tx_level = ~tx_level;
        bits.push_back({tx_level, 1'b0});
      end
    end
  endfunction

  function automatic void encode_action(input logic [1:0] act, input logic [7:0] b,
                                        ref line_bit_t bits[$]);
    logic [15:0] fcs;
    case (act)
      hfbe_pkg::ACT_FLAG: begin
        // flag goes out unstuffed and clears the ones run
        for (int i = 0; i < 8; i++) begin
          if (!hfbe_pkg::FLAG_PATTERN[i]) tx_level = ~tx_level;
          bits.push_back({tx_level, 1'b0});
        end
        tx_crc  = hfbe_pkg::CRC_INIT;
        tx_ones = 3'd0;
      end
      hfbe_pkg::ACT_DATA: begin
        stuff_byte(b, bits);
        tx_crc = fold_crc_byte(tx_crc, b);
      end
      hfbe_pkg::ACT_FCS: begin
        fcs = ~tx_crc;
        stuff_byte(fcs[7:0], bits);
        stuff_byte(fcs[15:8], bits);
      end
      default: begin
      end
    endcase
    if (bits.size() != 0) bits[bits.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  // called at a clock edge; leaves tvalid high after the accepting edge
  task automatic send_action(input logic [1:0] act, input logic [7:0] data,
                             input logic [4:0] n_bits, input logic [19:0] levels);
    line_bit_t bits[$];
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= data;
    do @(posedge clk); while (!s_axis_tready);
    encode_action(act, data, bits);
    if (n_bits != 0) begin
      bits = {};
      for (int i = 0; i < n_bits; i++) bits.push_back({levels[i], i == n_bits - 1});
    end
    foreach (bits[i]) line_q.push_back(bits[i]);
  endtask

  // hold off new requests until every expected line bit has come out
  task automatic drain_line();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (line_q.size() != 0);
  endtask

  task automatic random_frames(input int n_items);
    int sent;
    int n_data;
    logic [1:0] act;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        // noise: any code, unused one included
        act = 2'($urandom_range(3));
        send_action(act, 8'($urandom_range(255)), 5'd0, 20'd0);
        if (act != ACT_UNUSED) sent++;
      end else begin
        send_action(hfbe_pkg::ACT_FLAG, 8'($urandom_range(255)), 5'd0, 20'd0);
        sent++;
        n_data = $urandom_range(8);
        for (int i = 0; i < n_data; i++) begin
          // bias some bytes toward long runs of ones
          send_action(hfbe_pkg::ACT_DATA,
                      ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom_range(255)),
                      5'd0, 20'd0);
          sent++;
        end
        if ($urandom_range(4) != 0) begin
          send_action(hfbe_pkg::ACT_FCS, 8'($urandom_range(255)), 5'd0, 20'd0);
          sent++;
          if ($urandom_range(5) == 0) begin
            send_action(hfbe_pkg::ACT_FCS, 8'($urandom_range(255)), 5'd0, 20'd0);
            sent++;
          end
        end
        if ($urandom_range(7) == 0) drain_line();
      end
    end
  endtask

  // ---------------------------------------------------------------- sink side

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    line_bit_t exp_bit;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (line_q.size() == 0) begin
        report_mismatch($sformatf("line bit %0b last %0b with none expected",
                                  m_axis_tdata[0], m_axis_tlast));
      end else begin
        exp_bit = line_q.pop_front();
        if (m_axis_tdata[0] !== exp_bit.level)
          report_mismatch($sformatf("line bit %0b, expected %0b",
                                    m_axis_tdata[0], exp_bit.level));
        if (m_axis_tlast !== exp_bit.last)
          report_mismatch($sformatf("tlast %0b, expected %0b", m_axis_tlast, exp_bit.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("** hdlc_frame_bit_encoder_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    // typed rows follow from reset: line high, crc all ones, no ones run
    dir_rows.push_back({hfbe_pkg::ACT_FLAG, 8'h00, 5'd8, 20'h00080});
    dir_rows.push_back({hfbe_pkg::ACT_DATA, 8'h00, 5'd8, 20'h000AA});
    dir_rows.push_back({hfbe_pkg::ACT_DATA, 8'hFF, 5'd9, 20'h0001F});
    dir_rows.push_back({hfbe_pkg::ACT_DATA, 8'hFF, 5'd0, 20'h00000});
    dir_rows.push_back({hfbe_pkg::ACT_FCS,  8'h00, 5'd0, 20'h00000});
    dir_rows.push_back({hfbe_pkg::ACT_FCS,  8'h00, 5'd0, 20'h00000});
    dir_rows.push_back({ACT_UNUSED,         8'h00, 5'd0, 20'h00000});
    dir_rows.push_back({ACT_UNUSED,         8'hFF, 5'd0, 20'h00000});
    dir_rows.push_back({hfbe_pkg::ACT_FLAG, 8'hA5, 5'd0, 20'h00000});
    dir_rows.push_back({hfbe_pkg::ACT_DATA, 8'h7E, 5'd0, 20'h00000});
    dir_rows.push_back({hfbe_pkg::ACT_DATA, 8'h01, 5'd0, 20'h00000});
    dir_rows.push_back({hfbe_pkg::ACT_DATA, 8'h80, 5'd0, 20'h00000});
    dir_rows.push_back({hfbe_pkg::ACT_DATA, 8'h55, 5'd0, 20'h00000});
    dir_rows.push_back({hfbe_pkg::ACT_DATA, 8'hAA, 5'd0, 20'h00000});
    dir_rows.push_back({hfbe_pkg::ACT_DATA, 8'h1F, 5'd0, 20'h00000});
    dir_rows.push_back({hfbe_pkg::ACT_DATA, 8'hF8, 5'd0, 20'h00000});
    dir_rows.push_back({hfbe_pkg::ACT_FCS,  8'h00, 5'd0, 20'h00000});
    dir_rows.push_back({hfbe_pkg::ACT_FCS,  8'hFF, 5'd0, 20'h00000});
    dir_rows.push_back({hfbe_pkg::ACT_FLAG, 8'hFF, 5'd0, 20'h00000});
    dir_rows.push_back({hfbe_pkg::ACT_DATA, 8'hFF, 5'd0, 20'h00000});
    dir_rows.push_back({hfbe_pkg::ACT_DATA, 8'hFF, 5'd0, 20'h00000});
    dir_rows.push_back({hfbe_pkg::ACT_DATA, 8'hFF, 5'd0, 20'h00000});
    dir_rows.push_back({hfbe_pkg::ACT_FCS,  8'h00, 5'd0, 20'h00000});
    dir_rows.push_back({hfbe_pkg::ACT_FLAG, 8'h00, 5'd0, 20'h00000});

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_action(dir_rows[i].act, dir_rows[i].data, dir_rows[i].n_bits, dir_rows[i].levels);
    end
    drain_line();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 67; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 67; end
        default: begin src_idle_pct = 28; sink_stall_pct = 28; end
      endcase
      random_frames(PHASE_ITEMS);
      drain_line();
    end

    // catch any stray bits after the last expected one
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("** hdlc_frame_bit_encoder_top: PASSED **");
    end else begin
      $display("** hdlc_frame_bit_encoder_top: FAILED **");
    end
    $finish;
  end

endmodule

// File: hdlc_frame_bit_encoder_top.f
rtl/hfbe_pkg.sv
rtl/hfbe_front.sv
rtl/hfbe_ser.sv
rtl/hdlc_frame_bit_encoder_top.sv
rtl/hfbe_checker.sv
tb/hdlc_frame_bit_encoder_top_tb.sv
